// ===== src/tat_pkg.sv =====
// Shared types, constants and width helpers for the three-anchor trilateration solver.
package tat_pkg;

  localparam int TAT_COORD_WIDTH = 16;
  localparam int TAT_RANGE_WIDTH = 16;
  localparam int TAT_QUOT_BITS   = 32;
  localparam int TAT_OUT_WIDTH   = 32;

  // Control flags that travel beside the numerator and denominator magnitudes.
  typedef struct packed {
    logic valid;
    logic singular;
    logic neg_x;
    logic neg_y;
  } tat_flags_t;

  function automatic int tat_max(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Width of the coefficients -2 * (anchor difference).
  function automatic int tat_wa(input int c);
    return c + 2;
  endfunction

  // Width of the right-hand side differences.
  function automatic int tat_wb(input int c, input int r);
    return 2 * tat_max(c, r) + 3;
  endfunction

  // Width of the Cramer numerators.
  function automatic int tat_wn(input int c, input int r);
    return tat_wb(c, r) + tat_wa(c) + 1;
  endfunction

  // Width of the determinant.
  function automatic int tat_wd(input int c);
    return 2 * tat_wa(c) + 1;
  endfunction

endpackage

// ===== src/tat_solve.sv =====
// Front pipeline: builds the reduced linear system and its Cramer numerators and determinant.
module tat_solve #(
  parameter int COORD_WIDTH = 16,
  parameter int RANGE_WIDTH = 16
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   en,
  input  logic                                                   in_valid,
  input  logic signed [COORD_WIDTH-1:0]                          px [3],
  input  logic signed [COORD_WIDTH-1:0]                          py [3],
  input  logic        [RANGE_WIDTH-1:0]                          rng [3],
  output tat_pkg::tat_flags_t                                    flags,
  output logic [tat_pkg::tat_wn(COORD_WIDTH, RANGE_WIDTH)-1:0]   nmag_x,
  output logic [tat_pkg::tat_wn(COORD_WIDTH, RANGE_WIDTH)-1:0]   nmag_y,
  output logic [tat_pkg::tat_wd(COORD_WIDTH)-1:0]                dmag
);
  import tat_pkg::*;

  localparam int C  = COORD_WIDTH;
  localparam int R  = RANGE_WIDTH;
  localparam int WA = tat_wa(C);
  localparam int WB = tat_wb(C, R);
  localparam int WN = tat_wn(C, R);
  localparam int WD = tat_wd(C);
  localparam int WP = 2 * WA;
  localparam int BL = WB / 2;
  localparam int WH = WB - BL + WA;
  localparam int WL = BL + 1 + WA;

  // Stage 1: coefficient differences and squares.
  logic               v1_r;
  logic signed [WA-1:0] ax1_r [2], ax1_nxt [2];
  logic signed [WA-1:0] ay1_r [2], ay1_nxt [2];
  logic        [2*R-1:0] dsq_r [3], dsq_nxt [3];
  logic signed [2*C-1:0] xsq_r [3], xsq_nxt [3];
  logic signed [2*C-1:0] ysq_r [3], ysq_nxt [3];

  // Stage 2: right-hand sides and determinant products.
  logic               v2_r;
  logic signed [WB-1:0] b2_r [2], b2_nxt [2];
  logic signed [WP-1:0] pd_r [2], pd_nxt [2];
  logic signed [WA-1:0] ax2_r [2], ay2_r [2];

  // Stage 3: determinant and split numerator products.
  logic               v3_r;
  logic signed [WD-1:0] det3_r, det3_nxt;
  logic signed [WH-1:0] hi_r [4], hi_nxt [4];
  logic signed [WL-1:0] lo_r [4], lo_nxt [4];

  // Stage 4: numerators.
  logic               v4_r;
  logic signed [WD-1:0] det4_r;
  logic signed [WN-1:0] nx4_r, ny4_r, nx4_nxt, ny4_nxt;

  // Stage 5: magnitudes and signs.
  tat_flags_t         f5_r, f5_nxt;
  logic [WN-1:0]      nmx5_r, nmy5_r, nmx5_nxt, nmy5_nxt;
  logic [WD-1:0]      dm5_r, dm5_nxt;

  always_comb begin
    logic signed [C:0] diff;
    for (int k = 0; k < 2; k++) begin
      diff = {px[0][C-1], px[0]} - {px[k+1][C-1], px[k+1]};
      ax1_nxt[k] = {diff, 1'b0};
      diff = {py[0][C-1], py[0]} - {py[k+1][C-1], py[k+1]};
      ay1_nxt[k] = {diff, 1'b0};
    end
    for (int k = 0; k < 3; k++) begin
      dsq_nxt[k] = (2*R)'(rng[k]) * (2*R)'(rng[k]);
      xsq_nxt[k] = (2*C)'(px[k]) * (2*C)'(px[k]);
      ysq_nxt[k] = (2*C)'(py[k]) * (2*C)'(py[k]);
    end
  end

  always_comb begin
    logic signed [WB-1:0] rhs [3];
    for (int k = 0; k < 3; k++) begin
      rhs[k] = WB'($signed({1'b0, dsq_r[k]})) - WB'(xsq_r[k]) - WB'(ysq_r[k]);
    end
    b2_nxt[0] = rhs[1] - rhs[0];
    b2_nxt[1] = rhs[2] - rhs[0];
    pd_nxt[0] = WP'(ax1_r[0]) * WP'(ay1_r[1]);
    pd_nxt[1] = WP'(ax1_r[1]) * WP'(ay1_r[0]);
  end

  // Products in order: b1*ay2, b2*ay1, b2*ax1, b1*ax2.
  always_comb begin
    logic signed [WB-1:0] bsel [4];
    logic signed [WA-1:0] asel [4];
    bsel[0] = b2_r[0];  asel[0] = ay2_r[1];
    bsel[1] = b2_r[1];  asel[1] = ay2_r[0];
    bsel[2] = b2_r[1];  asel[2] = ax2_r[0];
    bsel[3] = b2_r[0];  asel[3] = ax2_r[1];
    for (int k = 0; k < 4; k++) begin
      hi_nxt[k] = WH'($signed(bsel[k][WB-1:BL])) * WH'(asel[k]);
      lo_nxt[k] = WL'($signed({1'b0, bsel[k][BL-1:0]})) * WL'(asel[k]);
    end
    det3_nxt = WD'(pd_r[0]) - WD'(pd_r[1]);
  end

  always_comb begin
    logic signed [WN-1:0] prod [4];
    for (int k = 0; k < 4; k++) begin
      prod[k] = (WN'(hi_r[k]) <<< BL) + WN'(lo_r[k]);
    end
    nx4_nxt = prod[0] - prod[1];
    ny4_nxt = prod[2] - prod[3];
  end

  always_comb begin
    logic dneg;
    dneg = det4_r[WD-1];
    f5_nxt.valid    = v4_r;
    f5_nxt.singular = (det4_r == '0);
    f5_nxt.neg_x    = nx4_r[WN-1] ^ dneg;
    f5_nxt.neg_y    = ny4_r[WN-1] ^ dneg;
    nmx5_nxt = nx4_r[WN-1] ? WN'(-nx4_r) : WN'(nx4_r);
    nmy5_nxt = ny4_r[WN-1] ? WN'(-ny4_r) : WN'(ny4_r);
    dm5_nxt  = dneg ? WD'(-det4_r) : WD'(det4_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      f5_r <= '0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      f5_r <= f5_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1_r  <= ax1_nxt;
      ay1_r  <= ay1_nxt;
      dsq_r  <= dsq_nxt;
      xsq_r  <= xsq_nxt;
      ysq_r  <= ysq_nxt;
      b2_r   <= b2_nxt;
      pd_r   <= pd_nxt;
      ax2_r  <= ax1_r;
      ay2_r  <= ay1_r;
      det3_r <= det3_nxt;
      hi_r   <= hi_nxt;
      lo_r   <= lo_nxt;
      det4_r <= det3_r;
      nx4_r  <= nx4_nxt;
      ny4_r  <= ny4_nxt;
      nmx5_r <= nmx5_nxt;
      nmy5_r <= nmy5_nxt;
      dm5_r  <= dm5_nxt;
    end
  end

  assign flags  = f5_r;
  assign nmag_x = nmx5_r;
  assign nmag_y = nmy5_r;
  assign dmag   = dm5_r;

endmodule

// ===== src/tat_div.sv =====
// Pipelined restoring divider, one quotient bit per stage for both coordinates, with saturation.
module tat_div #(
  parameter int COORD_WIDTH = 16,
  parameter int RANGE_WIDTH = 16
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   en,
  input  tat_pkg::tat_flags_t                                    flags,
  input  logic [tat_pkg::tat_wn(COORD_WIDTH, RANGE_WIDTH)-1:0]   nmag_x,
  input  logic [tat_pkg::tat_wn(COORD_WIDTH, RANGE_WIDTH)-1:0]   nmag_y,
  input  logic [tat_pkg::tat_wd(COORD_WIDTH)-1:0]                dmag,
  output logic                                                   res_valid,
  output logic signed [tat_pkg::TAT_OUT_WIDTH-1:0]               est_x,
  output logic signed [tat_pkg::TAT_OUT_WIDTH-1:0]               est_y,
  output logic                                                   singular,
  output logic                                                   overflow
);
  import tat_pkg::*;

  localparam int WN = tat_wn(COORD_WIDTH, RANGE_WIDTH);
  localparam int WD = tat_wd(COORD_WIDTH);
  localparam int QB = TAT_QUOT_BITS;
  localparam int WR = WD + QB;
  localparam int WC = tat_max(WN, WR);
  localparam int NS = QB + 1;
  localparam logic [QB-1:0] MAX_POS = {1'b0, {(QB-1){1'b1}}};
  localparam logic [QB-1:0] MIN_NEG = {1'b1, {(QB-1){1'b0}}};

  // Stage 0 holds the overflow pre-check; stages 1..QB each resolve one quotient bit.
  logic [NS-1:0]   v_r;
  logic [NS-1:0]   sing_r;
  logic [1:0]      neg_r [NS];
  logic [1:0]      pre_r [NS];
  logic [WD-1:0]   d_r   [NS];
  logic [WR-1:0]   rem_r [NS][2];
  logic [QB-1:0]   q_r   [NS][2];

  logic [1:0]      pre_nxt;
  logic [WR-1:0]   rem_nxt [NS][2];
  logic [QB-1:0]   q_nxt   [NS][2];

  logic            vo_r, so_r, ovf_r, ovf_nxt;
  logic signed [QB-1:0] ex_r, ey_r, ex_nxt, ey_nxt;

  // A quotient of 2^32 or more saturates whatever its sign.
  always_comb begin
    logic [WC-1:0] dref;
    dref = WC'({dmag, {QB{1'b0}}});
    pre_nxt[0] = (WC'(nmag_x) >= dref);
    pre_nxt[1] = (WC'(nmag_y) >= dref);
  end

  always_comb begin
    logic [WR:0] sub;
    rem_nxt[0][0] = WR'(nmag_x);
    rem_nxt[0][1] = WR'(nmag_y);
    q_nxt[0][0]   = '0;
    q_nxt[0][1]   = '0;
    for (int s = 1; s < NS; s++) begin
      for (int l = 0; l < 2; l++) begin
        sub = {1'b0, rem_r[s-1][l]} - {1'b0, WR'(d_r[s-1]) << (QB - s)};
        q_nxt[s][l] = q_r[s-1][l];
        if (!sub[WR]) begin
          rem_nxt[s][l]          = sub[WR-1:0];
          q_nxt[s][l][QB - s]    = 1'b1;
        end else begin
          rem_nxt[s][l] = rem_r[s-1][l];
        end
      end
    end
  end

  always_comb begin
    logic [QB-1:0]        q  [2];
    logic signed [QB-1:0] e  [2];
    logic [1:0]           ov;
    for (int l = 0; l < 2; l++) begin
      q[l] = q_r[NS-1][l];
      if (neg_r[NS-1][l]) begin
        ov[l] = pre_r[NS-1][l] || (q[l] > MIN_NEG);
        e[l]  = ov[l] ? MIN_NEG : -q[l];
      end else begin
        ov[l] = pre_r[NS-1][l] || q[l][QB-1];
        e[l]  = ov[l] ? MAX_POS : q[l];
      end
    end
    if (sing_r[NS-1]) begin
      ex_nxt  = '1;
      ey_nxt  = '1;
      ovf_nxt = 1'b0;
    end else begin
      ex_nxt  = e[0];
      ey_nxt  = e[1];
      ovf_nxt = |ov;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      vo_r <= 1'b0;
    end else if (en) begin
      v_r  <= {v_r[NS-2:0], flags.valid};
      vo_r <= v_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sing_r[0]   <= flags.singular;
      neg_r[0]    <= {flags.neg_y, flags.neg_x};
      pre_r[0]    <= pre_nxt;
      d_r[0]      <= dmag;
      rem_r[0][0] <= rem_nxt[0][0];
      rem_r[0][1] <= rem_nxt[0][1];
      q_r[0][0]   <= q_nxt[0][0];
      q_r[0][1]   <= q_nxt[0][1];
      for (int s = 1; s < NS; s++) begin
        sing_r[s] <= sing_r[s-1];
        neg_r[s]  <= neg_r[s-1];
        pre_r[s]  <= pre_r[s-1];
        d_r[s]    <= d_r[s-1];
        for (int l = 0; l < 2; l++) begin
          rem_r[s][l] <= rem_nxt[s][l];
          q_r[s][l]   <= q_nxt[s][l];
        end
      end
      so_r  <= sing_r[NS-1];
      ovf_r <= ovf_nxt;
      ex_r  <= ex_nxt;
      ey_r  <= ey_nxt;
    end
  end

  assign res_valid = vo_r;
  assign est_x     = ex_r;
  assign est_y     = ey_r;
  assign singular  = so_r;
  assign overflow  = ovf_r;

endmodule

// ===== src/three_anchor_trilateration_top.sv =====
// Top level of the three-anchor trilateration solver: stream ports, pipeline and output buffer.
//
// Each input transaction carries three anchors (x, y) and a measured range to each. The block
// solves the linear system left after subtracting the first circle from the other two, by the
// determinant and its cofactors, and returns one result transaction per input transaction in
// the same order. Each coordinate is the exact quotient truncated toward zero and saturated to
// 32 bits, with the overflow flag set when it saturates. Collinear or coincident anchors give a
// zero determinant: the singular flag is set and the position reads -1, -1.
//
// Throughput is one transaction per cycle while in_tready is high. From an accepted input to
// out_tvalid the path runs through five stages of multiplies and sums, an overflow pre-check,
// a 32-stage restoring divider that resolves one quotient bit per stage, a saturation stage
// and the output register. The whole pipeline advances together; a spare register behind the
// output register absorbs one transaction while the receiver stalls, so in_tready drops in the
// cycle after a stall reaches it and rises again once the spare register has drained.
// Synchronous active-low reset empties the pipeline and both output registers.
module three_anchor_trilateration_top #(
  parameter int COORD_WIDTH = tat_pkg::TAT_COORD_WIDTH,
  parameter int RANGE_WIDTH = tat_pkg::TAT_RANGE_WIDTH,
  parameter int IN_BITS     = 6 * COORD_WIDTH + 3 * RANGE_WIDTH,
  parameter int IN_TDATA_W  = (IN_BITS + 7) / 8 * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // anchor_a_x, anchor_a_y, range_a, anchor_b_x, anchor_b_y, range_b,
  // anchor_c_x, anchor_c_y, range_c, then zero padding
  input  logic [IN_TDATA_W-1:0] in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // est_x, est_y
  output logic [63:0]           out_tdata,
  // singular, overflow
  output logic [1:0]            out_tuser
);
  import tat_pkg::*;

  localparam int C   = COORD_WIDTH;
  localparam int R   = RANGE_WIDTH;
  localparam int AST = 2 * C + R;
  localparam int WN  = tat_wn(C, R);
  localparam int WD  = tat_wd(C);
  localparam int RW  = 2 * TAT_OUT_WIDTH + 2;

  logic signed [C-1:0] px [3], py [3];
  logic        [R-1:0] rng [3];

  tat_flags_t          flags;
  logic [WN-1:0]       nmag_x, nmag_y;
  logic [WD-1:0]       dmag;
  logic                res_valid, res_sing, res_ovf;
  logic signed [TAT_OUT_WIDTH-1:0] res_x, res_y;

  logic                en;
  logic                take_in, pop;
  logic [RW-1:0]       res_word;
  logic                out_v_r, skid_v_r;
  logic [RW-1:0]       out_d_r, skid_d_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      px[k]  = in_tdata[k*AST +: C];
      py[k]  = in_tdata[k*AST + C +: C];
      rng[k] = in_tdata[k*AST + 2*C +: R];
    end
  end

  assign en        = ~skid_v_r;
  assign in_tready = en;

  tat_solve #(
    .COORD_WIDTH(COORD_WIDTH),
    .RANGE_WIDTH(RANGE_WIDTH)
  ) u_solve (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_valid(in_tvalid),
    .px      (px),
    .py      (py),
    .rng     (rng),
    .flags   (flags),
    .nmag_x  (nmag_x),
    .nmag_y  (nmag_y),
    .dmag    (dmag)
  );

  tat_div #(
    .COORD_WIDTH(COORD_WIDTH),
    .RANGE_WIDTH(RANGE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .flags    (flags),
    .nmag_x   (nmag_x),
    .nmag_y   (nmag_y),
    .dmag     (dmag),
    .res_valid(res_valid),
    .est_x    (res_x),
    .est_y    (res_y),
    .singular (res_sing),
    .overflow (res_ovf)
  );

  assign res_word = {res_ovf, res_sing, res_y, res_x};
  assign take_in  = res_valid & en;
  assign pop      = out_v_r & out_tready;

  // Output register with a spare slot behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || pop) begin
      out_v_r  <= skid_v_r | take_in;
      skid_v_r <= 1'b0;
    end else if (take_in) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || pop) begin
      out_d_r <= skid_v_r ? skid_d_r : res_word;
    end else if (take_in) begin
      skid_d_r <= res_word;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r[2*TAT_OUT_WIDTH-1:0];
  assign out_tuser  = out_d_r[RW-1:2*TAT_OUT_WIDTH];

endmodule

// ===== src/tat_checker.sv =====
// Port-level checker for the trilateration solver, bound to its top level.
module tat_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result transaction changed");

  a_singular_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata == {64{1'b1}}) && !out_tuser[1])
    else $error("singular result without the -1, -1 position");

  a_overflow_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |->
      (out_tdata[31:0] == 32'h7FFFFFFF) || (out_tdata[31:0] == 32'h80000000) ||
      (out_tdata[63:32] == 32'h7FFFFFFF) || (out_tdata[63:32] == 32'h80000000))
    else $error("overflow flag without a saturated coordinate");

  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("input stalled without an output stall");

endmodule

bind three_anchor_trilateration_top tat_checker u_tat_checker (.*);
